FILE: hdl/assert_macros.svh
// Assertion macros shared by the RTL. Empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checked only out of reset.
`define KHC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Checked on every edge, reset included.
`define KHC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define KHC_ASSERT(lbl, clk, rst_n, prop, msg)
`define KHC_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

FILE: hdl/khc_pkg.sv
package khc_pkg;

    localparam int MAX_KMER_DEF    = 5;
    localparam int COUNT_WIDTH_DEF = 32;

    localparam int OP_W    = 2;
    localparam int CHAR_W  = 8;
    localparam int INDEX_W = 12;
    localparam int OUT_CNT_W = 32;
    localparam int CODE_W  = 3;
    localparam int KLEN_W  = 3;

    localparam logic [KLEN_W-1:0] KMER_LEN_RST = 3'd3;

    // nucleotide codes
    localparam logic [CODE_W-1:0] CODE_A     = 3'd0;
    localparam logic [CODE_W-1:0] CODE_C     = 3'd1;
    localparam logic [CODE_W-1:0] CODE_G     = 3'd2;
    localparam logic [CODE_W-1:0] CODE_T     = 3'd3;
    localparam logic [CODE_W-1:0] CODE_OTHER = 3'd4;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH  = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    function automatic int pow5(input int n);
        int p;
        p = 1;
        for (int i = 0; i < n; i++) begin
            p = p * 5;
        end
        return p;
    endfunction

    // case folded by setting bit 5
    function automatic logic [CODE_W-1:0] base_code(input logic [CHAR_W-1:0] ch);
        logic [CHAR_W-1:0] lc;
        lc = ch | 8'h20;
        case (lc)
            8'h61:        base_code = CODE_A;
            8'h63:        base_code = CODE_C;
            8'h67:        base_code = CODE_G;
            8'h74, 8'h75: base_code = CODE_T;
            default:      base_code = CODE_OTHER;
        endcase
    endfunction

endpackage

FILE: hdl/kmer_histogram_counter_unit.sv
// K-mer histogram counter. Each transaction (start high while busy is low)
// carries one op: push a sequence byte, read one counter, or clear the
// table and window to begin a new sequence. Every transaction gives exactly
// one result, shown on the o_ ports only in the cycle after the accepting
// edge and marked by o_valid; the receiver cannot stall, so it must take the
// result in that cycle. Pushes and reads are taken one per cycle, back to
// back; a push that repeats the k-mer of the push just before it is served
// from a forwarding register, so repeats need no gap. The counters live in
// one 5^MAX_KMER-entry memory (3125 at the default) with a synchronous
// read; each push of a formed k-mer is a read, then a saturating increment
// and write-back in the next cycle. A clear, and reset, sweeps the memory
// to zero one entry per cycle; busy stays high until the sweep is done, and
// no transaction is taken meanwhile. kmer_len may only be written while
// idle; 0 acts as 1 and values above MAX_KMER act as MAX_KMER.
`include "assert_macros.svh"

module kmer_histogram_counter_unit #(
    parameter int MAX_KMER    = khc_pkg::MAX_KMER_DEF,
    parameter int COUNT_WIDTH = khc_pkg::COUNT_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // transaction request
    input  logic                            start,
    output logic                            busy,
    input  logic [khc_pkg::OP_W-1:0]        i_op,
    input  logic [khc_pkg::CHAR_W-1:0]      i_base_char,
    input  logic [khc_pkg::INDEX_W-1:0]     i_entry_index,
    // configuration
    input  logic                            i_cfg_we,
    input  logic [khc_pkg::KLEN_W-1:0]      i_cfg_wdata,
    // result
    output logic                            o_valid,
    output logic [khc_pkg::INDEX_W-1:0]     o_kmer_slot,
    output logic                            o_kmer_formed,
    output logic [khc_pkg::OUT_CNT_W-1:0]   o_entry_count
);
    import khc_pkg::*;

    localparam int DEPTH     = pow5(MAX_KMER);
    localparam int AW        = $clog2(DEPTH);
    localparam int FW        = $clog2(MAX_KMER + 1);
    localparam int WIN_DEPTH = (MAX_KMER > 1) ? MAX_KMER - 1 : 1;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    logic [KLEN_W-1:0]      r_kmer_len;
    logic [CODE_W-1:0]      r_win [WIN_DEPTH];   // newest first
    logic [FW-1:0]          r_fill;

    // clearing sweep
    logic                   r_clr_active;
    logic [AW-1:0]          r_clr_addr;

    // stage B: item whose memory read is under way
    logic                   r_b_valid;
    t_op                    r_b_op;
    logic [AW-1:0]          r_b_addr;
    logic                   r_b_formed;
    logic                   r_b_rd_ok;

    // forwarding of the last write-back
    logic                   r_fwd;
    logic [COUNT_WIDTH-1:0] r_fwd_data;

    // counter memory
    logic [COUNT_WIDTH-1:0] r_mem [DEPTH];
    logic [COUNT_WIDTH-1:0] r_rdata;

    // ------------------------------------------------------------------
    // Accept stage
    // ------------------------------------------------------------------
    logic                   accept;
    t_op                    a_op;
    logic [CODE_W-1:0]      a_code;
    logic [FW-1:0]          k_eff;
    logic [FW-1:0]          n_fill;
    logic                   a_formed;
    logic [CODE_W-1:0]      codes [MAX_KMER];
    logic [AW-1:0]          a_kmer_addr;
    logic                   a_rd_ok;
    logic [AW-1:0]          n_raddr;

    assign busy   = r_clr_active;
    assign accept = start && !r_clr_active;
    assign a_op   = t_op'(i_op);
    assign a_code = base_code(i_base_char);

    always_comb begin
        if (r_kmer_len == '0) begin
            k_eff = FW'(1);
        end else if (int'(r_kmer_len) > MAX_KMER) begin
            k_eff = FW'(MAX_KMER);
        end else begin
            k_eff = FW'(r_kmer_len);
        end
    end

    assign n_fill   = (r_fill == FW'(MAX_KMER)) ? r_fill : r_fill + FW'(1);
    assign a_formed = (n_fill >= k_eff);

    // position j weighs 5^j; current code at position 0
    always_comb begin
        codes[0] = a_code;
        for (int j = 1; j < MAX_KMER; j++) begin
            codes[j] = r_win[j-1];
        end
        a_kmer_addr = '0;
        for (int j = 0; j < MAX_KMER; j++) begin
            if (j < int'(k_eff)) begin
                a_kmer_addr = a_kmer_addr + AW'(codes[j]) * AW'(pow5(j));
            end
        end
    end

    assign a_rd_ok = (32'(i_entry_index) < 32'(DEPTH));
    assign n_raddr = (a_op == OP_PUSH) ? a_kmer_addr : AW'(i_entry_index);

    // ------------------------------------------------------------------
    // Write-back stage
    // ------------------------------------------------------------------
    logic [COUNT_WIDTH-1:0] b_old;
    logic [COUNT_WIDTH-1:0] b_new;
    logic                   b_write;
    logic                   fwd_hit;
    logic                   mem_we;
    logic [AW-1:0]          mem_waddr;
    logic [COUNT_WIDTH-1:0] mem_wdata;

    assign b_old   = r_fwd ? r_fwd_data : r_rdata;
    assign b_new   = (b_old == '1) ? b_old : b_old + COUNT_WIDTH'(1);
    assign b_write = r_b_valid && (r_b_op == OP_PUSH) && r_b_formed;
    assign fwd_hit = b_write && (r_b_addr == n_raddr);

    always_comb begin
        if (r_clr_active) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_addr;
            mem_wdata = '0;
        end else begin
            mem_we    = b_write;
            mem_waddr = r_b_addr;
            mem_wdata = b_new;
        end
    end

    // read before write on the same address; forwarding covers that case
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[n_raddr];
    end

    // ------------------------------------------------------------------
    // Control and window
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kmer_len   <= KMER_LEN_RST;
            r_fill       <= '0;
            r_clr_active <= 1'b1;
            r_clr_addr   <= '0;
            r_b_valid    <= 1'b0;
            r_fwd        <= 1'b0;
            for (int i = 0; i < WIN_DEPTH; i++) begin
                r_win[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_kmer_len <= i_cfg_wdata;
            end

            if (r_clr_active) begin
                r_clr_addr <= r_clr_addr + AW'(1);
                if (r_clr_addr == AW'(DEPTH - 1)) begin
                    r_clr_active <= 1'b0;
                end
            end

            r_b_valid <= accept;
            r_fwd     <= accept && fwd_hit;

            if (accept && (a_op == OP_PUSH)) begin
                r_fill   <= n_fill;
                r_win[0] <= a_code;
                for (int i = 1; i < WIN_DEPTH; i++) begin
                    r_win[i] <= r_win[i-1];
                end
            end

            if (accept && (a_op == OP_CLEAR)) begin
                r_fill       <= '0;
                r_clr_active <= 1'b1;
                r_clr_addr   <= '0;
                for (int i = 0; i < WIN_DEPTH; i++) begin
                    r_win[i] <= '0;
                end
            end
        end
    end

    // payload of stage B
    always_ff @(posedge i_clk) begin
        r_fwd_data <= b_new;
        if (accept) begin
            r_b_op     <= a_op;
            r_b_addr   <= n_raddr;
            r_b_formed <= a_formed;
            r_b_rd_ok  <= a_rd_ok;
        end
    end

    // ------------------------------------------------------------------
    // Result
    // ------------------------------------------------------------------
    assign o_valid       = r_b_valid;
    assign o_kmer_formed = b_write;
    assign o_kmer_slot   = b_write ? INDEX_W'(r_b_addr) : '0;
    assign o_entry_count = (r_b_valid && (r_b_op == OP_READ) && r_b_rd_ok)
                           ? OUT_CNT_W'(b_old) : '0;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `KHC_ASSERT(a_result_follows_accept, i_clk, i_rst_n, o_valid |-> $past(start && !busy), "result without a preceding transaction")
    `KHC_ASSERT(a_fwd_from_push, i_clk, i_rst_n, r_fwd |-> $past(b_write), "forwarding flag set without a write-back")
    `KHC_ASSERT(a_sweep_complete, i_clk, i_rst_n, $fell(r_clr_active) |-> ($past(r_clr_addr) == AW'(DEPTH - 1)), "clearing sweep ended early")
    `KHC_ASSERT(a_no_result_in_sweep, i_clk, i_rst_n, ($past(r_clr_active) && r_clr_active) |-> !o_valid, "result during clearing sweep")

endmodule
